/* hw/rtl/fcss_pkg.sv */
// FAT12 chain sector sequencer: shared types, mode codes and constants.
// No dependencies; imported by fcss_in_buf, fcss_walker, the top level and the testbench.
`default_nettype none

package fcss_pkg;

    typedef enum logic [1:0] {
        MODE_WRITE_FAT = 2'd0,
        MODE_OPEN      = 2'd1,
        MODE_CONSUME   = 2'd2,
        MODE_UNUSED    = 2'd3
    } mode_t;

    localparam logic CFG_DATA_START = 1'b0;
    localparam logic CFG_SPC        = 1'b1;

    // bytes in one sector buffer; the grant and offset fields are sized for it
    localparam int SECTOR_SIZE = 512;

    // cluster numbers at or above this end the chain
    localparam logic [11:0] CHAIN_END = 12'hFF8;

    typedef struct packed {
        logic [1:0]  mode;
        logic [12:0] fat_address;
        logic [7:0]  fat_byte;
        logic [11:0] start_cluster;
        logic [31:0] file_length;
        logic        is_directory;
        logic [9:0]  byte_count;
    } item_t;

    typedef struct packed {
        logic [9:0]  granted_bytes;
        logic [8:0]  buffer_offset;
        logic        fetch_valid;
        logic [31:0] fetch_lba;
        logic        end_of_file;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_LO,
        ST_RD_HI,
        ST_MUL,
        ST_ADD,
        ST_EMIT
    } walk_state_t;

endpackage

`default_nettype wire

/* hw/rtl/fcss_fat_ram.sv */
// Single-port FAT byte store, one access per cycle, registered read data.
// Depends on nothing; used by fcss_walker through the top level.
`default_nettype none

module fcss_fat_ram #(
    parameter int DEPTH = 8192,
    parameter int AW    = 13
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] addr,
    input  wire logic [7:0]    wdata,
    output logic      [7:0]    rdata
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

/* hw/rtl/fcss_in_buf.sv */
// Input word register: unpacks the slave stream into an item and holds it
// until the walker takes it. Depends on fcss_pkg.
`default_nettype none

module fcss_in_buf
    import fcss_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [79:0] s_axis_tdata,
    input  wire logic [2:0]  s_axis_tuser,
    output item_t            item_o,
    output logic             item_valid_o,
    input  wire logic        item_take_i
);

    logic  valid_reg, valid_next;
    item_t item_reg, item_next;
    logic  accept;

    assign s_axis_tready = !valid_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        item_next  = item_reg;
        valid_next = valid_reg;
        if (item_take_i) begin
            valid_next = 1'b0;
        end
        if (accept) begin
            valid_next              = 1'b1;
            item_next.mode          = s_axis_tuser[1:0];
            item_next.is_directory  = s_axis_tuser[2];
            item_next.fat_address   = s_axis_tdata[12:0];
            item_next.fat_byte      = s_axis_tdata[20:13];
            item_next.start_cluster = s_axis_tdata[32:21];
            item_next.file_length   = s_axis_tdata[64:33];
            item_next.byte_count    = s_axis_tdata[74:65];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        item_reg <= item_next;
    end

    assign item_o       = item_reg;
    assign item_valid_o = valid_reg;

endmodule

`default_nettype wire

/* hw/rtl/fcss_walker.sv */
// Chain walker: file state, grant arithmetic, FAT entry fetch over the
// single-port store, LBA multiply and add. Depends on fcss_pkg.
`default_nettype none

module fcss_walker
    import fcss_pkg::*;
#(
    parameter int FAT_BYTES    = 8192,
    parameter int AW           = 13
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire item_t         item_i,
    input  wire logic          item_valid_i,
    output logic               item_take_o,
    output result_t            res_o,
    output logic               res_valid_o,
    input  wire logic          res_ready_i,
    input  wire logic [31:0]   data_start_lba,
    input  wire logic [7:0]    sectors_per_cluster,
    output logic               ram_we,
    output logic      [AW-1:0] ram_addr,
    output logic      [7:0]    ram_wdata,
    input  wire logic [7:0]    ram_rdata
);

    localparam int SBW = $clog2(SECTOR_SIZE);
    localparam int GW  = (SBW + 1 > 10) ? SBW + 1 : 10;

    walk_state_t state_reg, state_next;
    logic [31:0] position_reg, position_next;
    logic [31:0] limit_reg, limit_next;
    logic [11:0] cluster_reg, cluster_next;
    logic [6:0]  sic_reg, sic_next;
    logic        unclamped_reg, unclamped_next;
    logic        done_reg, done_next;
    logic [7:0]  lo_reg, lo_next;
    logic [31:0] prod_reg, prod_next;
    result_t     res_reg, res_next;

    // grant arithmetic on the held item
    logic [SBW-1:0] rel;
    logic [GW-1:0]  left, req, n, grant;
    logic [31:0]    rest, pos_after;
    logic           sector_end;
    logic [7:0]     sic_inc;
    logic           follow;
    logic           stay_at_end;
    logic [13:0]    at_lo, at_hi;
    logic [15:0]    fat_word;
    logic [11:0]    successor;
    logic           succ_end;
    logic [31:0]    cl_m2;

    assign rel       = position_reg[SBW-1:0];
    assign left      = GW'(SECTOR_SIZE) - GW'(rel);
    assign req       = GW'(item_i.byte_count);
    assign rest      = limit_reg - position_reg;
    assign n         = (!unclamped_reg && (rest < 32'(req))) ? GW'(rest) : req;
    assign grant     = (n < left) ? n : left;
    assign pos_after = position_reg + 32'(grant);
    assign sector_end = (grant != '0) && (grant == left);
    assign sic_inc   = {1'b0, sic_reg} + 8'd1;
    assign follow    = sic_inc >= sectors_per_cluster;
    // a sector step inside an already terminal cluster still ends the file
    assign stay_at_end = !follow && (cluster_reg >= CHAIN_END);

    // entry of cluster c sits at byte c*3/2
    assign at_lo     = {2'b00, cluster_reg} + {3'b000, cluster_reg[11:1]};
    assign at_hi     = at_lo + 14'd1;
    assign fat_word  = {ram_rdata, lo_reg};
    assign successor = cluster_reg[0] ? fat_word[15:4] : fat_word[11:0];
    assign succ_end  = successor >= CHAIN_END;
    assign cl_m2     = {20'd0, cluster_reg} - 32'd2;

    assign item_take_o = (state_reg == ST_IDLE) && item_valid_i;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (item_valid_i) begin
                    case (item_i.mode)
                        MODE_OPEN: state_next = ST_MUL;
                        MODE_CONSUME: begin
                            if (done_reg || !sector_end || stay_at_end) begin
                                state_next = ST_EMIT;
                            end else if (follow) begin
                                state_next = ST_RD_LO;
                            end else begin
                                state_next = ST_MUL;
                            end
                        end
                        default: state_next = ST_EMIT;
                    endcase
                end
            end
            ST_RD_LO: state_next = ST_RD_HI;
            ST_RD_HI: state_next = succ_end ? ST_EMIT : ST_MUL;
            ST_MUL:   state_next = ST_ADD;
            ST_ADD:   state_next = ST_EMIT;
            ST_EMIT: begin
                if (res_ready_i) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // datapath and memory port
    always_comb begin
        position_next  = position_reg;
        limit_next     = limit_reg;
        cluster_next   = cluster_reg;
        sic_next       = sic_reg;
        unclamped_next = unclamped_reg;
        done_next      = done_reg;
        lo_next        = lo_reg;
        prod_next      = prod_reg;
        res_next       = res_reg;
        ram_we         = 1'b0;
        ram_addr       = AW'(at_lo);
        ram_wdata      = item_i.fat_byte;
        case (state_reg)
            ST_IDLE: begin
                if (item_valid_i) begin
                    res_next = '0;
                    case (item_i.mode)
                        MODE_WRITE_FAT: begin
                            ram_addr = AW'(item_i.fat_address);
                            ram_we   = 32'(item_i.fat_address) < 32'(FAT_BYTES);
                        end
                        MODE_OPEN: begin
                            cluster_next         = item_i.start_cluster;
                            position_next        = '0;
                            limit_next           = item_i.file_length;
                            sic_next             = '0;
                            unclamped_next       = item_i.is_directory &&
                                                   (item_i.file_length == '0);
                            done_next            = 1'b0;
                            res_next.fetch_valid = 1'b1;
                        end
                        MODE_CONSUME: begin
                            if (done_reg) begin
                                res_next.end_of_file = 1'b1;
                            end else begin
                                res_next.granted_bytes = grant[9:0];
                                res_next.buffer_offset = 9'(rel);
                                position_next          = pos_after;
                                if (sector_end) begin
                                    if (follow) begin
                                        sic_next = '0;
                                    end else begin
                                        sic_next = sic_inc[6:0];
                                    end
                                    if (stay_at_end) begin
                                        limit_next     = pos_after;
                                        unclamped_next = unclamped_reg &&
                                                         (pos_after == '0);
                                        done_next      = 1'b1;
                                        res_next.end_of_file = 1'b1;
                                    end else if (!follow) begin
                                        res_next.fetch_valid = 1'b1;
                                    end
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_RD_LO: begin
                lo_next  = ram_rdata;
                ram_addr = AW'(at_hi);
            end
            ST_RD_HI: begin
                cluster_next = successor;
                if (succ_end) begin
                    limit_next     = position_reg;
                    unclamped_next = unclamped_reg && (position_reg == '0);
                    done_next      = 1'b1;
                    res_next.end_of_file = 1'b1;
                end else begin
                    res_next.fetch_valid = 1'b1;
                end
            end
            ST_MUL: begin
                prod_next = 32'(cl_m2 * {24'd0, sectors_per_cluster});
            end
            ST_ADD: begin
                res_next.fetch_lba = data_start_lba + prod_reg + {25'd0, sic_reg};
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            position_reg  <= '0;
            limit_reg     <= '0;
            cluster_reg   <= '0;
            sic_reg       <= '0;
            unclamped_reg <= 1'b0;
            done_reg      <= 1'b0;
        end else begin
            state_reg     <= state_next;
            position_reg  <= position_next;
            limit_reg     <= limit_next;
            cluster_reg   <= cluster_next;
            sic_reg       <= sic_next;
            unclamped_reg <= unclamped_next;
            done_reg      <= done_next;
        end
        lo_reg   <= lo_next;
        prod_reg <= prod_next;
        res_reg  <= res_next;
    end

    assign res_o       = res_reg;
    assign res_valid_o = (state_reg == ST_EMIT);

endmodule

`default_nettype wire

/* hw/rtl/fat12_chain_sector_sequencer_top.sv */
// FAT12 chain sector sequencer top: config registers, input word register,
// walker, FAT store and output word register; the input register takes a new word
// while the walker works. Straight to emit: FAT writes, ended, mid-sector and
// terminal-cluster consumes. Multiply and add: an open or a sector step. Two FAT
// reads, then multiply and add if the entry leads to a next cluster, else emit.
// Reset (aresetn, synchronous) clears file state and handshakes; FAT is not cleared.
`default_nettype none

module fat12_chain_sector_sequencer_top
    import fcss_pkg::*;
#(
    parameter int FAT_BYTES    = 8192
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // fat_address[12:0], fat_byte[20:13], start_cluster[32:21],
    // file_length[64:33], byte_count[74:65], zero fill
    input  wire logic [79:0] s_axis_tdata,
    // mode[1:0], is_directory[2]
    input  wire logic [2:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // granted_bytes[9:0], buffer_offset[18:10], fetch_lba[50:19], zero fill
    output logic      [55:0] m_axis_tdata,
    // fetch_valid[0], end_of_file[1]
    output logic      [1:0]  m_axis_tuser,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_addr,
    input  wire logic [31:0] cfg_wdata
);

    localparam int AW = $clog2(FAT_BYTES);

    logic [31:0] data_start_reg, data_start_next;
    logic [7:0]  spc_reg, spc_next;
    item_t       item;
    logic        item_valid, item_take;
    result_t     res;
    logic        res_valid, slot_free;
    result_t     out_reg, out_next;
    logic        out_valid_reg, out_valid_next;
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [7:0]    ram_wdata, ram_rdata;

    always_comb begin
        data_start_next = data_start_reg;
        spc_next        = spc_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_DATA_START: data_start_next = cfg_wdata;
                CFG_SPC:        spc_next        = cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    fcss_in_buf u_in_buf (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .item_o       (item),
        .item_valid_o (item_valid),
        .item_take_i  (item_take)
    );

    fcss_walker #(
        .FAT_BYTES   (FAT_BYTES),
        .AW          (AW)
    ) u_walker (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .item_i             (item),
        .item_valid_i       (item_valid),
        .item_take_o        (item_take),
        .res_o              (res),
        .res_valid_o        (res_valid),
        .res_ready_i        (slot_free),
        .data_start_lba     (data_start_reg),
        .sectors_per_cluster(spc_reg),
        .ram_we             (ram_we),
        .ram_addr           (ram_addr),
        .ram_wdata          (ram_wdata),
        .ram_rdata          (ram_rdata)
    );

    fcss_fat_ram #(
        .DEPTH(FAT_BYTES),
        .AW   (AW)
    ) u_fat_ram (
        .aclk (aclk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    // output word register: free when empty or being taken this cycle
    assign slot_free = !out_valid_reg || m_axis_tready;

    always_comb begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
        if (res_valid && slot_free) begin
            out_next       = res;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_start_reg <= '0;
            spc_reg        <= 8'd1;
            out_valid_reg  <= 1'b0;
        end else begin
            data_start_reg <= data_start_next;
            spc_reg        <= spc_next;
            out_valid_reg  <= out_valid_next;
        end
        out_reg <= out_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_reg.fetch_lba, out_reg.buffer_offset,
                            out_reg.granted_bytes};
    assign m_axis_tuser  = {out_reg.end_of_file, out_reg.fetch_valid};

    // a result never both asks for a sector and reports end of file
    a_fetch_xor_eof: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("fetch and end of file in one result");

    // no address without a fetch request
    a_lba_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[50:19] == 32'd0))
        else $error("fetch_lba set without fetch_valid");

    // a grant never runs past the end of the sector buffer
    a_grant_in_sector: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |->
            ((14'(m_axis_tdata[9:0]) + 14'(m_axis_tdata[18:10])) <= 14'(SECTOR_SIZE)))
        else $error("grant crosses sector end");

endmodule

`default_nettype wire

/* tb/tb_fat12_chain_sector_sequencer_top.sv */
// Self-checking testbench for fat12_chain_sector_sequencer_top: builds FAT12 chains,
// opens files on them and walks them with split byte requests under random stalls.
// Depends on fcss_pkg (item/result types, mode codes, register indexes, chain end).

module tb_fat12_chain_sector_sequencer_top;
    import fcss_pkg::*;

    localparam int SECTOR      = 512;
    localparam int FAT_DEPTH   = 8192;
    localparam int CYCLE_LIMIT = 600000;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // fat_address, fat_byte, start_cluster, file_length, byte_count, zero fill
    logic [79:0] s_axis_tdata;
    // mode, is_directory
    logic [2:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // granted_bytes, buffer_offset, fetch_lba, zero fill
    logic [55:0] m_axis_tdata;
    // fetch_valid, end_of_file
    logic [1:0]  m_axis_tuser;
    logic        cfg_wr_en;
    logic        cfg_addr;
    logic [31:0] cfg_wdata;

    fat12_chain_sector_sequencer_top u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    // Shadow of the walker: FAT contents, file position and the queue of
    // results each accepted word must produce.
    class chain_scoreboard;
        logic [31:0] data_start;
        logic [7:0]  spc;
        logic [7:0]  fat_mem [FAT_DEPTH];
        bit          fat_set [FAT_DEPTH];
        logic [31:0] pos;
        logic [31:0] limit;
        logic [11:0] cluster;
        logic [6:0]  sector;
        bit          unclamped;
        bit          done;
        result_t     pending [$];
        int          errors;
        int          checked;

        function new();
            data_start = '0;
            spc        = 8'd1;
            for (int i = 0; i < FAT_DEPTH; i++) begin
                fat_mem[i] = '0;
                fat_set[i] = 1'b0;
            end
            pos       = '0;
            limit     = '0;
            cluster   = '0;
            sector    = '0;
            unclamped = 1'b0;
            done      = 1'b0;
            errors    = 0;
            checked   = 0;
        endfunction

        function void set_reg(logic idx, logic [31:0] value);
            if (idx == CFG_DATA_START)
                data_start = value;
            else
                spc = value[7:0];
        endfunction

        function logic [31:0] lba_of(logic [11:0] cl);
            logic [31:0] rel;
            rel = {20'd0, cl} - 32'd2;
            return data_start + rel * {24'd0, spc};
        endfunction

        function logic [11:0] successor(logic [11:0] cl);
            int unsigned at;
            logic [15:0] pair;
            at   = ({20'd0, cl} * 3) / 2;
            pair = {fat_mem[at + 1], fat_mem[at]};
            return cl[0] ? pair[15:4] : pair[11:0];
        endfunction

        function logic [9:0] grant_for(logic [9:0] n);
            logic [31:0] want;
            logic [31:0] rest;
            logic [9:0]  left;
            want = {22'd0, n};
            left = 10'(SECTOR) - {1'b0, pos[8:0]};
            if (!unclamped) begin
                rest = limit - pos;
                if (rest < want)
                    want = rest;
            end
            return (want < {22'd0, left}) ? want[9:0] : left;
        endfunction

        // True when a request of n bytes would make the walker read a FAT entry.
        function bit steps_cluster(logic [9:0] n, output int unsigned at);
            logic [9:0] g;
            logic [9:0] left;
            g    = grant_for(n);
            left = 10'(SECTOR) - {1'b0, pos[8:0]};
            at   = ({20'd0, cluster} * 3) / 2;
            return !done && g != 0 && g == left && ({25'd0, sector} + 1 >= {24'd0, spc});
        endfunction

        function void note_item(item_t it);
            result_t     r;
            logic [9:0]  g;
            logic [9:0]  left;
            logic [31:0] next;
            r = '0;
            case (mode_t'(it.mode))
                MODE_WRITE_FAT: begin
                    fat_mem[it.fat_address] = it.fat_byte;
                    fat_set[it.fat_address] = 1'b1;
                end
                MODE_OPEN: begin
                    cluster       = it.start_cluster;
                    pos           = '0;
                    limit         = it.file_length;
                    sector        = '0;
                    unclamped     = it.is_directory && it.file_length == 0;
                    done          = 1'b0;
                    r.fetch_valid = 1'b1;
                    r.fetch_lba   = lba_of(cluster);
                end
                MODE_CONSUME: begin
                    if (done) begin
                        r.end_of_file = 1'b1;
                    end else begin
                        g               = grant_for(it.byte_count);
                        left            = 10'(SECTOR) - {1'b0, pos[8:0]};
                        r.granted_bytes = g;
                        r.buffer_offset = pos[8:0];
                        pos             = pos + {22'd0, g};
                        if (g != 0 && g == left) begin
                            next = {25'd0, sector} + 1;
                            if (next >= {24'd0, spc}) begin
                                sector  = '0;
                                cluster = successor(cluster);
                            end else begin
                                sector = next[6:0];
                            end
                            if (cluster >= CHAIN_END) begin
                                limit         = pos;
                                unclamped     = unclamped && pos == 0;
                                done          = 1'b1;
                                r.end_of_file = 1'b1;
                            end else begin
                                r.fetch_valid = 1'b1;
                                r.fetch_lba   = lba_of(cluster) + {25'd0, sector};
                            end
                        end
                    end
                end
                default: ;
            endcase
            pending.push_back(r);
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        task check_result(result_t got);
            result_t want;
            if (pending.size() == 0) begin
                report($sformatf("result word %h arrived with nothing pending", got));
            end else begin
                want = pending.pop_front();
                checked++;
                if (got.granted_bytes !== want.granted_bytes)
                    report($sformatf("result %0d granted_bytes %0d, expected %0d",
                                     checked, got.granted_bytes, want.granted_bytes));
                if (got.buffer_offset !== want.buffer_offset)
                    report($sformatf("result %0d buffer_offset %0d, expected %0d",
                                     checked, got.buffer_offset, want.buffer_offset));
                if (got.fetch_valid !== want.fetch_valid)
                    report($sformatf("result %0d fetch_valid %b, expected %b",
                                     checked, got.fetch_valid, want.fetch_valid));
                if (got.fetch_lba !== want.fetch_lba)
                    report($sformatf("result %0d fetch_lba %h, expected %h",
                                     checked, got.fetch_lba, want.fetch_lba));
                if (got.end_of_file !== want.end_of_file)
                    report($sformatf("result %0d end_of_file %b, expected %b",
                                     checked, got.end_of_file, want.end_of_file));
            end
        endtask
    endclass

    chain_scoreboard sb;
    bit      idle_en;
    int      items_sent;
    int      settings_used;
    result_t seen_word;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("TB_ERROR");
        $finish;
    end

    // Result side: drop ready with a 30 percent chance unless idling is off.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_axis_tready <= !(idle_en && $urandom_range(0, 99) < 30);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            seen_word.granted_bytes = m_axis_tdata[9:0];
            seen_word.buffer_offset = m_axis_tdata[18:10];
            seen_word.fetch_lba     = m_axis_tdata[50:19];
            seen_word.fetch_valid   = m_axis_tuser[0];
            seen_word.end_of_file   = m_axis_tuser[1];
            sb.check_result(seen_word);
        end
    end

    // Hold valid until accepted; the next call changes it at the following falling edge.
    task automatic send_item(item_t it);
        @(negedge aclk);
        while (idle_en && $urandom_range(0, 99) < 30) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, it.byte_count, it.file_length, it.start_cluster,
                          it.fat_byte, it.fat_address};
        s_axis_tuser  <= {it.is_directory, it.mode};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        sb.note_item(it);
        items_sent++;
    endtask

    function automatic item_t random_item();
        item_t it;
        it.mode          = 2'($urandom_range(0, 3));
        it.fat_address   = 13'($urandom);
        it.fat_byte      = 8'($urandom);
        it.start_cluster = 12'($urandom);
        it.file_length   = $urandom;
        it.is_directory  = 1'($urandom);
        it.byte_count    = 10'($urandom_range(0, SECTOR));
        return it;
    endfunction

    task automatic drain();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    task automatic write_config(logic [31:0] start, logic [7:0] spc);
        drain();
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= CFG_DATA_START;
        cfg_wdata <= start;
        @(negedge aclk);
        cfg_addr  <= CFG_SPC;
        cfg_wdata <= {24'd0, spc};
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_reg(CFG_DATA_START, start);
        sb.set_reg(CFG_SPC, {24'd0, spc});
        settings_used++;
    endtask

    task automatic write_fat(int unsigned addr, logic [7:0] value);
        item_t it;
        it             = random_item();
        it.mode        = MODE_WRITE_FAT;
        it.fat_address = 13'(addr);
        it.fat_byte    = value;
        send_item(it);
    endtask

    // Rewrite the two bytes that hold a 12-bit entry, keeping the neighbor's nibble.
    task automatic set_entry(logic [11:0] cl, logic [11:0] val);
        int unsigned at;
        logic [7:0]  b0;
        logic [7:0]  b1;
        at = ({20'd0, cl} * 3) / 2;
        b0 = sb.fat_mem[at];
        b1 = sb.fat_mem[at + 1];
        if (!cl[0]) begin
            b0 = val[7:0];
            b1 = {b1[7:4], val[11:8]};
        end else begin
            b0 = {val[3:0], b0[3:0]};
            b1 = val[11:4];
        end
        write_fat(at, b0);
        write_fat(at + 1, b1);
    endtask

    task automatic open_file(logic [11:0] cl, logic [31:0] len, bit dir);
        item_t it;
        it               = random_item();
        it.mode          = MODE_OPEN;
        it.start_cluster = cl;
        it.file_length   = len;
        it.is_directory  = dir;
        send_item(it);
    endtask

    // Fill any unwritten FAT bytes the walker is about to read, then send the consume.
    task automatic consume(logic [9:0] n);
        item_t       it;
        int unsigned at;
        if (sb.steps_cluster(n, at)) begin
            if (!sb.fat_set[at])
                write_fat(at, 8'($urandom));
            if (!sb.fat_set[at + 1])
                write_fat(at + 1, 8'($urandom));
        end
        it            = random_item();
        it.mode       = MODE_CONSUME;
        it.byte_count = n;
        send_item(it);
    endtask

    function automatic logic [9:0] pick_request();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 10'(SECTOR);
        if (r < 60)
            return 10'($urandom_range(0, SECTOR));
        if (r < 75)
            return 10'(SECTOR) - {1'b0, sb.pos[8:0]};
        if (r < 85)
            return 10'd0;
        return 10'($urandom_range(1, 16));
    endfunction

    task automatic run_file();
        logic [11:0] chain [$];
        logic [11:0] tail;
        logic [31:0] len;
        int          n_cl;
        int          base;
        int          step;
        int          spc_eff;
        int          cap;
        int          kind;
        int          n_use;
        bit          dir;
        bit          was_done;
        bit          was_full;
        n_cl = $urandom_range(1, 4);
        base = $urandom_range(2, 3000);
        step = $urandom_range(1, 200);
        for (int i = 0; i < n_cl; i++)
            chain.push_back(12'(base + i * step));
        for (int i = 0; i < n_cl; i++) begin
            tail = (i + 1 < n_cl) ? chain[i + 1] : 12'($urandom_range(12'hFF8, 12'hFFF));
            set_entry(chain[i], tail);
        end
        spc_eff = (sb.spc == 0) ? 1 : ((sb.spc > 128) ? 128 : int'(sb.spc));
        cap     = n_cl * spc_eff * SECTOR;
        kind    = $urandom_range(0, 9);
        dir     = 1'b0;
        case (kind)
            0: begin
                dir = 1'b1;
                len = '0;
            end
            1: len = '0;
            2: len = $urandom;
            3: len = 32'($urandom_range(1, cap / SECTOR) * SECTOR);
            default: begin
                len = 32'($urandom_range(1, cap + 600));
                dir = 1'($urandom);
            end
        endcase
        open_file(chain[0], len, dir);
        n_use = $urandom_range(6, 20);
        for (int k = 0; k < n_use; k++) begin
            was_done = sb.done;
            was_full = sb.pos == sb.limit && !sb.unclamped;
            consume(pick_request());
            if (was_done || was_full)
                break;
        end
    endtask

    task automatic noise_item();
        item_t it;
        int    pick;
        it   = random_item();
        pick = $urandom_range(0, 3);
        if (pick == 3) begin
            consume(10'($urandom_range(0, SECTOR)));
        end else begin
            it.mode = (pick == 0) ? MODE_WRITE_FAT : ((pick == 1) ? MODE_UNUSED : MODE_OPEN);
            send_item(it);
        end
    endtask

    task automatic random_files(int count);
        int target;
        target = items_sent + count;
        while (items_sent < target) begin
            if ($urandom_range(0, 9) < 8)
                run_file();
            else
                noise_item();
        end
    endtask

    task automatic directed_items();
        item_t it;
        set_entry(12'd2, 12'd3);
        set_entry(12'd3, 12'hFFF);
        write_fat(FAT_DEPTH - 1, 8'hFF);
        write_fat(0, 8'h00);
        // unused mode with every other field at its top value, byte_count at one sector
        it               = '1;
        it.mode          = MODE_UNUSED;
        it.byte_count    = 10'(SECTOR);
        send_item(it);
        open_file(12'd2, 32'd1000, 1'b0);
        consume(10'd0);
        consume(10'd1);
        consume(10'(SECTOR));
        consume(10'(SECTOR));
        consume(10'(SECTOR));
        // empty directory: unclamped until the chain ends
        open_file(12'd3, 32'd0, 1'b1);
        consume(10'(SECTOR));
        consume(10'd100);
        // clusters below two wrap the sector arithmetic
        open_file(12'd0, 32'hFFFF_FFFF, 1'b0);
        open_file(12'd1, 32'd5, 1'b1);
        consume(10'(SECTOR));
        set_entry(12'hFFF, CHAIN_END);
        open_file(12'hFFF, 32'd600, 1'b0);
        consume(10'(SECTOR));
    endtask

    // Above 128 sectors per cluster the 7-bit counter wraps inside one cluster.
    task automatic wrap_sectors();
        open_file(12'($urandom_range(2, 100)), 32'd0, 1'b1);
        repeat (130) consume(10'(SECTOR));
    endtask

    initial begin
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        cfg_wr_en     = 1'b0;
        cfg_addr      = CFG_DATA_START;
        cfg_wdata     = '0;
        idle_en       = 1'b1;
        items_sent    = 0;
        settings_used = 0;
        sb            = new();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        write_config(32'd0, 8'd1);
        directed_items();
        random_files(60);
        write_config(32'hFFFF_FFFF, 8'd128);
        random_files(60);
        write_config($urandom, 8'd0);
        random_files(60);
        // long stretch with both sides always ready
        idle_en = 1'b0;
        write_config($urandom, 8'($urandom_range(2, 8)));
        random_files(60);
        idle_en = 1'b1;
        write_config($urandom, 8'd255);
        wrap_sectors();
        write_config($urandom, 8'd3);
        random_files(60);
        drain();

        $display("Summary: %0d input words, %0d results checked over %0d register settings",
                 items_sent, sb.checked, settings_used);
        $display("Covered FAT writes, opens, split and clamped consumes, chain ends, counter wrap");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* files.f */
hw/rtl/fcss_pkg.sv
hw/rtl/fcss_fat_ram.sv
hw/rtl/fcss_in_buf.sv
hw/rtl/fcss_walker.sv
hw/rtl/fat12_chain_sector_sequencer_top.sv
tb/tb_fat12_chain_sector_sequencer_top.sv
